FILE: src/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types and constants for the binary record deframer.
// ----------------------------------------------------------------------------
package brd_pkg;

  localparam int LENGTH_GROUPS_DEF = 4;
  localparam int COUNT_BITS_DEF    = 32;

  localparam int KIND_W  = 15;
  localparam int LEN_W   = 28;
  localparam int COUNT_W = 32;
  localparam int SHEET_W = 16;
  localparam int BYTES_W = 40;

  localparam logic [7:0]        LOW7_MASK     = 8'h7F;
  localparam logic [7:0]        CONT_BIT      = 8'h80;
  localparam logic [KIND_W-1:0] ROW_HDR_ID    = 15'h0000;
  localparam logic [KIND_W-1:0] CELL_FIRST_ID = 15'h0001;
  localparam logic [KIND_W-1:0] CELL_LAST_ID  = 15'h000B;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       part_end;
  } beat_t;

  typedef struct packed {
    logic               record_done;
    logic [KIND_W-1:0]  record_kind;
    logic [LEN_W-1:0]   record_length;
    logic               part_done;
    logic [COUNT_W-1:0] record_total;
    logic [COUNT_W-1:0] row_total;
    logic [COUNT_W-1:0] cell_total;
    logic [COUNT_W-1:0] top_row;
    logic [COUNT_W-1:0] top_column;
    logic [SHEET_W-1:0] sheet_total;
    logic [BYTES_W-1:0] byte_total;
  } result_t;

endpackage

FILE: src/brd_parse.sv
// ----------------------------------------------------------------------------
// brd_parse
// Record framing state and statistics counters; one byte per step.
// ----------------------------------------------------------------------------
module brd_parse #(
  parameter int LENGTH_GROUPS = brd_pkg::LENGTH_GROUPS_DEF,
  parameter int COUNT_BITS    = brd_pkg::COUNT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  brd_pkg::beat_t  beat,
  output logic            emit,
  output brd_pkg::result_t res
);
  import brd_pkg::*;

  localparam int LG_W  = $clog2(LENGTH_GROUPS + 1);
  localparam int CNT_W = (COUNT_BITS >= COUNT_W) ? COUNT_W : COUNT_BITS;

  localparam logic [2:0] PH_ID0   = 3'd0;
  localparam logic [2:0] PH_ID1   = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_BODY  = 3'd3;
  localparam logic [2:0] PH_STALL = 3'd4;

  logic [2:0]         phase, phase_next;
  logic [KIND_W-1:0]  kind_acc, kind_next;
  logic [LEN_W-1:0]   len_acc, len_next;
  logic [LG_W-1:0]    grp, grp_next;
  logic [LEN_W-1:0]   left, left_next;
  logic [31:0]        head_word, head_next;
  logic [2:0]         head_cnt, head_cnt_next;
  logic [CNT_W-1:0]   recs, recs_next;
  logic [CNT_W-1:0]   rows, rows_next;
  logic [CNT_W-1:0]   cells, cells_next;
  logic [31:0]        row_peak, row_peak_next;
  logic [31:0]        col_peak, col_peak_next;
  logic [SHEET_W-1:0] sheets, sheets_next;
  logic [BYTES_W-1:0] bytes, bytes_next;

  logic [7:0]       b;
  logic [5:0]       grp_shift;
  logic [34:0]      grp_wide;
  logic [LEN_W-1:0] len_or;
  logic [31:0]      head_body;
  logic [LEN_W-1:0] rec_len;
  logic             done;
  logic             is_row, is_cell, wide_rec;

  assign b         = beat.data_byte;
  assign grp_shift = 6'(grp) * 6'd7;
  assign grp_wide  = 35'(b & LOW7_MASK) << grp_shift;
  assign len_or    = len_acc | grp_wide[LEN_W-1:0];
  assign head_body = (head_cnt < 3'd4) ?
                     (head_word | (32'(b) << {head_cnt[1:0], 3'b000})) : head_word;

  always_comb begin
    phase_next    = phase;
    kind_next     = kind_acc;
    len_next      = len_acc;
    grp_next      = grp;
    left_next     = left;
    head_next     = head_word;
    head_cnt_next = head_cnt;
    done          = 1'b0;
    case (phase)
      PH_ID0: begin
        head_next     = '0;
        head_cnt_next = '0;
        len_next      = '0;
        grp_next      = '0;
        kind_next     = KIND_W'(b & LOW7_MASK);
        phase_next    = ((b & CONT_BIT) != 8'h00) ? PH_ID1 : PH_LEN;
      end
      PH_ID1: begin
        kind_next  = {b, kind_acc[6:0]};
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        len_next = len_or;
        grp_next = grp + LG_W'(1);
        if ((b & CONT_BIT) == 8'h00) begin
          if (len_or == '0) begin
            done = 1'b1;
          end else begin
            left_next  = len_or;
            phase_next = PH_BODY;
          end
        end else if (grp_next >= LG_W'(LENGTH_GROUPS)) begin
          // size never terminates: park until the part ends
          phase_next = PH_STALL;
        end
      end
      PH_BODY: begin
        head_next = head_body;
        if (head_cnt < 3'd4) begin
          head_cnt_next = head_cnt + 3'd1;
        end
        left_next = left - LEN_W'(1);
        if (left_next == '0) begin
          done = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (done) begin
      phase_next = PH_ID0;
    end
    if (beat.part_end) begin
      phase_next    = PH_ID0;
      kind_next     = '0;
      len_next      = '0;
      grp_next      = '0;
      left_next     = '0;
      head_next     = '0;
      head_cnt_next = '0;
    end
  end

  // record completes only in LEN (empty body) or BODY; kind is stable there
  assign rec_len  = (phase == PH_LEN) ? len_or : len_acc;
  assign wide_rec = rec_len >= LEN_W'(4);
  assign is_row   = done && (kind_acc == ROW_HDR_ID) && wide_rec;
  assign is_cell  = done && (kind_acc >= CELL_FIRST_ID) && (kind_acc <= CELL_LAST_ID);

  always_comb begin
    recs_next     = (done && !(&recs)) ? recs + CNT_W'(1) : recs;
    rows_next     = (is_row && !(&rows)) ? rows + CNT_W'(1) : rows;
    cells_next    = (is_cell && !(&cells)) ? cells + CNT_W'(1) : cells;
    row_peak_next = (is_row && head_body > row_peak) ? head_body : row_peak;
    col_peak_next = (is_cell && wide_rec && head_body > col_peak) ? head_body : col_peak;
    sheets_next   = (beat.part_end && !(&sheets)) ? sheets + SHEET_W'(1) : sheets;
    bytes_next    = !(&bytes) ? bytes + BYTES_W'(1) : bytes;
  end

  assign emit = done || beat.part_end;

  always_comb begin
    res.record_done   = done;
    res.record_kind   = done ? kind_acc : '0;
    res.record_length = done ? rec_len : '0;
    res.part_done     = beat.part_end;
    res.record_total  = COUNT_W'(recs_next);
    res.row_total     = COUNT_W'(rows_next);
    res.cell_total    = COUNT_W'(cells_next);
    res.top_row       = row_peak_next;
    res.top_column    = col_peak_next;
    res.sheet_total   = sheets_next;
    res.byte_total    = bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_ID0;
      kind_acc  <= '0;
      len_acc   <= '0;
      grp       <= '0;
      left      <= '0;
      head_word <= '0;
      head_cnt  <= '0;
      recs      <= '0;
      rows      <= '0;
      cells     <= '0;
      row_peak  <= '0;
      col_peak  <= '0;
      sheets    <= '0;
      bytes     <= '0;
    end else if (step) begin
      phase     <= phase_next;
      kind_acc  <= kind_next;
      len_acc   <= len_next;
      grp       <= grp_next;
      left      <= left_next;
      head_word <= head_next;
      head_cnt  <= head_cnt_next;
      recs      <= recs_next;
      rows      <= rows_next;
      cells     <= cells_next;
      row_peak  <= row_peak_next;
      col_peak  <= col_peak_next;
      sheets    <= sheets_next;
      bytes     <= bytes_next;
    end
  end

endmodule

FILE: src/binary_record_deframer_with_stats.sv
// ----------------------------------------------------------------------------
// binary_record_deframer_with_stats
// Splits an inflated binary spreadsheet part into records and keeps stats.
// ----------------------------------------------------------------------------
// Takes one byte beat per cycle unless the input stalls, and registers a
// result beat from the byte in the input register whenever that byte
// completes a record or ends a part. The rate is set by the framing state
// update, which is combinational between the input register and the result
// register. Input stalls only when the result register is still full and the
// byte waiting in the input register produces a result of its own.
module binary_record_deframer_with_stats #(
  parameter int LENGTH_GROUPS = brd_pkg::LENGTH_GROUPS_DEF,
  parameter int COUNT_BITS    = brd_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  brd_pkg::beat_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output brd_pkg::result_t result
);
  import brd_pkg::*;

  logic    s1_valid;
  beat_t   s1_beat;
  logic    advance;
  logic    emit;
  result_t res;

  brd_parse #(
    .LENGTH_GROUPS (LENGTH_GROUPS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .beat (s1_beat),
    .emit (emit),
    .res  (res)
  );

  // a byte that yields nothing never waits on the result register
  assign advance    = s1_valid && (!emit || !result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_beat <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result <= res;
    end
  end

endmodule

FILE: src/brd_checker.sv
// ----------------------------------------------------------------------------
// brd_checker
// Port-level checks on the record deframer, bound to the top level.
// ----------------------------------------------------------------------------
module brd_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input brd_pkg::beat_t   item,
  input logic             result_valid,
  input logic             result_ready,
  input brd_pkg::result_t result
);
  import brd_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.record_done || result.part_done)
    else $error("result beat with neither record nor part end");

  a_no_rec_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.record_done |->
      result.record_kind == '0 && result.record_length == '0)
    else $error("record fields set without a completed record");

  a_rec_counted: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.record_done |->
      result.record_total != '0 && result.byte_total != '0)
    else $error("completed record not counted");

  a_sheet_counted: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.part_done |-> result.sheet_total != '0)
    else $error("part end not counted");

endmodule

bind binary_record_deframer_with_stats brd_checker u_brd_checker (.*);

FILE: test/tb_binary_record_deframer_with_stats.sv
// ----------------------------------------------------------------------------
// tb_binary_record_deframer_with_stats
// Self-checking bench for the binary record deframer and its statistics.
// ----------------------------------------------------------------------------
// Parts are built as byte streams: mostly well-formed records (short and
// two-byte ids, padded sizes, row headers and cells with random head words),
// plus noise, truncated records and sizes that never terminate. An internal
// tracker follows the framing and counters per accepted beat and queues the
// result each beat should produce; every result beat is matched field by
// field. Both sides idle in short random bursts, the receiver once holds off
// long enough to back up the input, and the sender drains now and then.
// ----------------------------------------------------------------------------
module tb_binary_record_deframer_with_stats;
  timeunit 1ns;
  timeprecision 1ps;

  import brd_pkg::*;

  localparam int          QUIET_LIMIT  = 2000;
  localparam int          TARGET_BEATS = 1500;
  localparam int          CALM_BEATS   = 1300;
  localparam int          HOLD_CYCLES  = 64;
  localparam logic [31:0] COUNT_CAP    = (COUNT_BITS_DEF >= 32) ? 32'hFFFF_FFFF :
                                         32'((64'd1 << COUNT_BITS_DEF) - 1);

  typedef enum logic [2:0] {AT_ID0, AT_ID1, AT_SIZE, AT_BODY, AT_STUCK} frame_phase_t;

  // Follows the record framing and running totals, holds results still due.
  class record_stats_tracker;
    frame_phase_t       phase      = AT_ID0;
    logic [KIND_W-1:0]  kind_acc   = '0;
    logic [LEN_W-1:0]   size_acc   = '0;
    int unsigned        size_group = 0;
    logic [LEN_W-1:0]   body_left  = '0;
    logic [31:0]        head_word  = '0;
    int unsigned        head_count = 0;
    logic [COUNT_W-1:0] records    = '0;
    logic [COUNT_W-1:0] rows       = '0;
    logic [COUNT_W-1:0] cells      = '0;
    logic [COUNT_W-1:0] row_peak   = '0;
    logic [COUNT_W-1:0] col_peak   = '0;
    logic [SHEET_W-1:0] sheets     = '0;
    logic [BYTES_W-1:0] bytes_fed  = '0;
    result_t            due_results[$];
    int unsigned        errors     = 0;

    function void take_byte(beat_t b);
      logic    done;
      result_t r;
      done = 1'b0;
      if (bytes_fed != '1) bytes_fed++;
      case (phase)
        AT_ID0: begin
          head_word  = '0;
          head_count = 0;
          size_acc   = '0;
          size_group = 0;
          kind_acc   = KIND_W'(b.data_byte & LOW7_MASK);
          phase      = ((b.data_byte & CONT_BIT) != 0) ? AT_ID1 : AT_SIZE;
        end
        AT_ID1: begin
          kind_acc = kind_acc | (KIND_W'(b.data_byte) << 7);
          phase    = AT_SIZE;
        end
        AT_SIZE: begin
          size_acc = size_acc | (LEN_W'(b.data_byte & LOW7_MASK) << (7 * size_group));
          size_group++;
          if ((b.data_byte & CONT_BIT) == 0) begin
            if (size_acc == 0) begin
              done = 1'b1;
            end else begin
              body_left = size_acc;
              phase     = AT_BODY;
            end
          end else if (size_group >= LENGTH_GROUPS_DEF) begin
            phase = AT_STUCK;
          end
        end
        AT_BODY: begin
          if (head_count < 4) begin
            head_word = head_word | (32'(b.data_byte) << (8 * head_count));
            head_count++;
          end
          body_left--;
          if (body_left == 0) done = 1'b1;
        end
        default: ;
      endcase

      if (done) begin
        if (records < COUNT_CAP) records++;
        if (kind_acc == ROW_HDR_ID) begin
          if (size_acc >= 4) begin
            if (rows < COUNT_CAP) rows++;
            if (head_word > row_peak) row_peak = head_word;
          end
        end else if (kind_acc >= CELL_FIRST_ID && kind_acc <= CELL_LAST_ID) begin
          if (cells < COUNT_CAP) cells++;
          if (size_acc >= 4 && head_word > col_peak) col_peak = head_word;
        end
        phase = AT_ID0;
      end

      r.record_done   = done;
      r.record_kind   = done ? kind_acc : '0;
      r.record_length = done ? size_acc : '0;

      // part end drops whatever record is half built
      if (b.part_end) begin
        if (sheets != '1) sheets++;
        phase      = AT_ID0;
        kind_acc   = '0;
        size_acc   = '0;
        size_group = 0;
        body_left  = '0;
        head_word  = '0;
        head_count = 0;
      end

      r.part_done    = b.part_end;
      r.record_total = records;
      r.row_total    = rows;
      r.cell_total   = cells;
      r.top_row      = row_peak;
      r.top_column   = col_peak;
      r.sheet_total  = sheets;
      r.byte_total   = bytes_fed;
      if (done || b.part_end) due_results = {due_results, r};
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare("record_done",   64'(want.record_done),   64'(got.record_done));
      compare("record_kind",   64'(want.record_kind),   64'(got.record_kind));
      compare("record_length", 64'(want.record_length), 64'(got.record_length));
      compare("part_done",     64'(want.part_done),     64'(got.part_done));
      compare("record_total",  64'(want.record_total),  64'(got.record_total));
      compare("row_total",     64'(want.row_total),     64'(got.row_total));
      compare("cell_total",    64'(want.cell_total),    64'(got.cell_total));
      compare("top_row",       64'(want.top_row),       64'(got.top_row));
      compare("top_column",    64'(want.top_column),    64'(got.top_column));
      compare("sheet_total",   64'(want.sheet_total),   64'(got.sheet_total));
      compare("byte_total",    64'(want.byte_total),    64'(got.byte_total));
    endfunction
  endclass

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  beat_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  record_stats_tracker tracker  = new();
  beat_t       part_bytes[$];
  int unsigned beats_sent   = 0;
  int unsigned quiet_cycles = 0;
  bit          calm         = 1'b0;
  bit          hold_rx      = 1'b0;

  binary_record_deframer_with_stats uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---- stream building ----

  function automatic void add_byte(logic [7:0] d);
    beat_t b;
    b.data_byte = d;
    b.part_end  = 1'b0;
    part_bytes  = {part_bytes, b};
  endfunction

  function automatic void end_part();
    beat_t b;
    b = part_bytes[part_bytes.size() - 1];
    b.part_end = 1'b1;
    part_bytes[part_bytes.size() - 1] = b;
  endfunction

  function automatic void add_record(logic [KIND_W-1:0] kind, int unsigned body_len,
                                     bit wide_id, int unsigned pad_groups,
                                     logic [31:0] head);
    int unsigned groups;
    logic [7:0]  d;
    groups = 1;
    while (groups < LENGTH_GROUPS_DEF && (body_len >> (7 * groups)) != 0) groups++;
    groups = groups + pad_groups;
    if (groups > LENGTH_GROUPS_DEF) groups = LENGTH_GROUPS_DEF;
    if (wide_id || kind > 127) begin
      add_byte(8'(kind[6:0]) | CONT_BIT);
      add_byte(kind[14:7]);
    end else begin
      add_byte(8'(kind));
    end
    for (int unsigned i = 0; i < groups; i++) begin
      d = 8'(body_len >> (7 * i)) & LOW7_MASK;
      if (i + 1 < groups) d = d | CONT_BIT;
      add_byte(d);
    end
    for (int unsigned i = 0; i < body_len; i++) begin
      add_byte(i < 4 ? head[8 * i +: 8] : 8'($urandom));
    end
  endfunction

  function automatic void add_random_record();
    int unsigned    pick;
    int unsigned    body_len;
    logic [KIND_W-1:0] kind;
    logic [31:0]    head;
    pick = $urandom_range(0, 9);
    if (pick < 3)       kind = ROW_HDR_ID;
    else if (pick < 7)  kind = KIND_W'($urandom_range(CELL_FIRST_ID, CELL_LAST_ID));
    else if (pick == 7) kind = KIND_W'($urandom_range(12, 127));
    else                kind = KIND_W'($urandom);
    pick = $urandom_range(0, 39);
    if (pick < 6)       body_len = $urandom_range(0, 3);
    else if (pick < 34) body_len = $urandom_range(4, 10);
    else if (pick < 39) body_len = $urandom_range(11, 40);
    else                body_len = $urandom_range(128, 200);
    pick = $urandom_range(0, 3);
    if (pick == 0)      head = 32'hFFFF_FFFF;
    else if (pick == 1) head = 32'($urandom_range(0, 255));
    else                head = $urandom;
    add_record(kind, body_len, $urandom_range(0, 3) == 0,
               ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0, head);
  endfunction

  function automatic void build_part();
    int unsigned style;
    int unsigned start;
    int unsigned added;
    style = $urandom_range(0, 19);
    if (style == 0) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
    end else if (style == 1) begin
      // size keeps continuing past its last group, rest of part is dead
      add_byte(8'($urandom_range(0, 127)));
      repeat (LENGTH_GROUPS_DEF) add_byte(8'($urandom) | CONT_BIT);
      repeat ($urandom_range(0, 5)) add_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 5)) add_random_record();
      if (style == 2) begin
        start = part_bytes.size();
        add_random_record();
        added = part_bytes.size() - start;
        if (added > 1) begin
          repeat ($urandom_range(1, added - 1)) part_bytes.delete(part_bytes.size() - 1);
        end
      end
    end
    end_part();
  endfunction

  // ---- driving ----

  task automatic send_part();
    beat_t b;
    while (part_bytes.size() > 0) begin
      b = part_bytes.pop_front();
      if (!calm && $urandom_range(0, 7) == 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      item       <= b;
      item_valid <= 1'b1;
      do @(posedge clk); while (!item_ready);
      tracker.take_byte(b);
      beats_sent++;
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      if (hold_rx) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) tracker.match_result(result);
    if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // row header with all-ones word, largest cell id, widest id with empty body
    add_record(ROW_HDR_ID, 4, 1'b0, 0, 32'hFFFF_FFFF);
    add_record(CELL_LAST_ID, 4, 1'b0, 0, 32'h0000_1234);
    add_record(15'h7FFF, 0, 1'b1, 0, 32'h0);
    end_part();
    // size that never terminates, then a byte ignored until the part end
    add_byte(8'h0C);
    repeat (LENGTH_GROUPS_DEF) add_byte(CONT_BIT);
    add_byte(8'h00);
    end_part();
    // largest four-group size, record cut short by the part end
    add_byte(8'h02);
    repeat (LENGTH_GROUPS_DEF - 1) add_byte(8'hFF);
    add_byte(LOW7_MASK);
    add_byte(8'hAA);
    end_part();
    send_part();
    drain();

    // back-pressure: receiver holds off while empty records stream in
    hold_rx = 1'b1;
    repeat (24) add_record(CELL_FIRST_ID, 0, 1'b0, 0, 32'h0);
    end_part();
    send_part();
    drain();

    while (beats_sent < TARGET_BEATS) begin
      calm = (beats_sent >= CALM_BEATS);
      build_part();
      send_part();
      if (!calm && $urandom_range(0, 15) == 0) drain();
    end

    item_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
